// ===== rtl/sgd_pkg.sv =====
// Shared types and constants for the Shift-JIS glyph index decoder.
`timescale 1ns / 1ps

package sgd_pkg;

    // Glyph kinds
    localparam logic [1:0] KIND_HALF = 2'd0;
    localparam logic [1:0] KIND_FULL = 2'd1;
    localparam logic [1:0] KIND_EXT  = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    // Byte codes
    localparam logic [7:0] BYTE_DOLLAR   = 8'h24;
    localparam logic [7:0] BYTE_LOWER_A  = 8'h61;
    localparam logic [7:0] BYTE_UPPER_A  = 8'h41;
    localparam logic [7:0] LEAD_LO_BASE  = 8'h81;
    localparam logic [7:0] LEAD_HI_BASE  = 8'hE0;
    localparam logic [6:0] LEAD_HI_ROW   = 7'h20;
    localparam logic [7:0] TRAIL_LO_BASE = 8'h40;
    localparam logic [7:0] TRAIL_MID_BASE = 8'h80;
    localparam logic [6:0] TRAIL_MID_COL = 7'h3F;
    localparam logic [7:0] TRAIL_HI_BASE = 8'h9F;

    localparam int TDATA_W = 32;
    localparam int TUSER_W = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] half_code;
        logic [6:0] row_index;
        logic [6:0] column_index;
        logic       face_bank;
        logic [4:0] external_letter;
        logic       external_upper;
    } t_glyph;

    // One queue word: the results caused by one input byte (one or two)
    typedef struct packed {
        logic   two;
        t_glyph res0;
        t_glyph res1;
    } t_entry;

endpackage

// ===== rtl/sgd_front.sv =====
// Front end: accepts text bytes, tracks lead and dollar state, builds result words.
`timescale 1ns / 1ps

module sgd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_eot,
    input  logic          i_queue_full,
    output logic          o_push,
    output sgd_pkg::t_entry o_entry
);
    import sgd_pkg::*;

    logic       r_face;
    logic       r_dollar;
    logic       r_lead;
    logic [7:0] r_lead_value;
    logic       n_dollar;
    logic       n_lead;
    logic [7:0] n_lead_value;

    logic       accept;
    t_glyph     blank;
    t_glyph     fresh_res;
    logic       fresh_has;
    logic       fresh_dollar;
    logic       fresh_lead;
    t_glyph     res0;
    t_glyph     res1;
    logic [1:0] cnt;
    logic [6:0] ku;
    t_glyph     tail_res;
    logic       tail_has;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    // Decode of a byte with nothing pending
    always_comb begin
        blank           = '0;
        blank.face_bank = r_face;
        fresh_res       = blank;
        fresh_has       = 1'b0;
        fresh_dollar    = 1'b0;
        fresh_lead      = 1'b0;
        if (i_byte == BYTE_DOLLAR) begin
            fresh_dollar = 1'b1;
        end else if (i_byte inside {[8'h81:8'h9F], [8'hE0:8'hEF]}) begin
            fresh_lead = 1'b1;
        end else if (i_byte inside {[8'h00:8'h7F], [8'hA1:8'hDF]}) begin
            fresh_has           = 1'b1;
            fresh_res.kind      = KIND_HALF;
            fresh_res.half_code = i_byte;
        end else begin
            fresh_has      = 1'b1;
            fresh_res.kind = KIND_BAD;
        end
    end

    always_comb begin
        if (r_lead_value < 8'hA0) begin
            ku = 7'(r_lead_value - LEAD_LO_BASE);
        end else begin
            ku = 7'(r_lead_value - LEAD_HI_BASE) + LEAD_HI_ROW;
        end
        ku = {ku[5:0], 1'b0};
    end

    always_comb begin
        res0         = blank;
        res1         = blank;
        cnt          = 2'd0;
        n_dollar     = r_dollar;
        n_lead       = r_lead;
        n_lead_value = r_lead_value;
        tail_res     = blank;
        tail_has     = 1'b0;

        if (r_dollar) begin
            n_dollar = 1'b0;
            cnt      = 2'd1;
            if (i_byte inside {[8'h61:8'h7A]}) begin
                res0.kind            = KIND_EXT;
                res0.external_letter = 5'(i_byte - BYTE_LOWER_A);
            end else if (i_byte inside {[8'h41:8'h5A]}) begin
                res0.kind            = KIND_EXT;
                res0.external_letter = 5'(i_byte - BYTE_UPPER_A);
                res0.external_upper  = 1'b1;
            end else begin
                res0.kind      = KIND_HALF;
                res0.half_code = BYTE_DOLLAR;
                if (i_byte != BYTE_DOLLAR) begin
                    // lone dollar: emit it, then decode this byte afresh
                    res1     = fresh_res;
                    n_dollar = fresh_dollar;
                    n_lead   = fresh_lead;
                    if (fresh_lead) begin
                        n_lead_value = i_byte;
                    end
                    if (fresh_has) begin
                        cnt = 2'd2;
                    end
                end
            end
        end else if (r_lead) begin
            n_lead = 1'b0;
            cnt    = 2'd1;
            if (i_byte inside {[8'h40:8'h7E]}) begin
                res0.kind         = KIND_FULL;
                res0.row_index    = ku;
                res0.column_index = 7'(i_byte - TRAIL_LO_BASE);
            end else if (i_byte inside {[8'h80:8'h9E]}) begin
                res0.kind         = KIND_FULL;
                res0.row_index    = ku;
                res0.column_index = 7'(i_byte - TRAIL_MID_BASE) + TRAIL_MID_COL;
            end else if (i_byte inside {[8'h9F:8'hFC]}) begin
                res0.kind         = KIND_FULL;
                res0.row_index    = ku + 7'd1;
                res0.column_index = 7'(i_byte - TRAIL_HI_BASE);
            end else begin
                res0.kind = KIND_BAD;
            end
        end else begin
            res0     = fresh_res;
            n_dollar = fresh_dollar;
            n_lead   = fresh_lead;
            if (fresh_lead) begin
                n_lead_value = i_byte;
            end
            cnt = {1'b0, fresh_has};
        end

        // flush pending state at end of text
        if (i_eot) begin
            if (n_dollar) begin
                tail_has           = 1'b1;
                tail_res.kind      = KIND_HALF;
                tail_res.half_code = BYTE_DOLLAR;
            end else if (n_lead) begin
                tail_has      = 1'b1;
                tail_res.kind = KIND_BAD;
            end
            if (tail_has) begin
                if (cnt == 2'd0) begin
                    res0 = tail_res;
                    cnt  = 2'd1;
                end else begin
                    res1 = tail_res;
                    cnt  = 2'd2;
                end
            end
            n_dollar     = 1'b0;
            n_lead       = 1'b0;
            n_lead_value = '0;
        end
    end

    assign o_push       = accept && (cnt != 2'd0);
    assign o_entry.two  = (cnt == 2'd2);
    assign o_entry.res0 = res0;
    assign o_entry.res1 = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face       <= 1'b0;
            r_dollar     <= 1'b0;
            r_lead       <= 1'b0;
            r_lead_value <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_face <= i_cfg_data;
            end
            if (accept) begin
                r_dollar     <= n_dollar;
                r_lead       <= n_lead;
                r_lead_value <= n_lead_value;
            end
        end
    end

endmodule

// ===== rtl/sgd_queue.sv =====
// Short queue between the front and back ends.
`timescale 1ns / 1ps

module sgd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/sgd_back.sv =====
// Back end: splits queued words into single results behind an output register.
`timescale 1ns / 1ps

module sgd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sgd_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output sgd_pkg::t_glyph o_glyph,
    output logic            o_last
);
    import sgd_pkg::*;

    logic   r_valid;
    t_glyph r_glyph;
    logic   r_last;
    logic   r_sel;
    logic   load;
    logic   is_last;

    assign load    = !r_valid || i_ready;
    assign is_last = r_sel || !i_entry.two;
    assign o_pop   = load && i_valid && is_last;

    assign o_valid = r_valid;
    assign o_glyph = r_glyph;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_glyph <= r_sel ? i_entry.res1 : i_entry.res0;
            r_last  <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
            // advance to the second result, or back to the first on pop
            if (i_valid) begin
                r_sel <= !is_last;
            end
        end
    end

endmodule

// ===== rtl/sjis_glyph_index_decoder_unit.sv =====
// Top level of the Shift-JIS glyph index decoder.
`timescale 1ns / 1ps

// Decodes a Shift-JIS text, one byte per input word, into glyph addresses.
// Input stream: tdata[7:0] is the text byte, tlast marks the last byte of text.
// Output stream: tuser is the glyph kind (half, full, external, invalid);
// tdata carries half code, row, column, face bank, external letter and case;
// tlast marks the final result caused by one input byte.
// Each byte gives zero, one or two results: lead bytes and '$' wait for the
// next byte; a lone '$' before a byte that is not a letter, '$' or lead gives two.
// The cfg channel writes the face select bit; write it only while idle.
// An accepted byte's results are written into the queue, then moved to the
// output register. Throughput: one byte per cycle, limited only by the output
// side, which delivers one result per cycle while the receiver is ready.
// A queue of QUEUE_DEPTH words separates the byte decoder from the result
// serializer; input ready drops only when that queue is full, so a stalled
// receiver backs up the queue before the input stalls.
// Reset (synchronous, active low) clears the pending lead and dollar state,
// the face select, the queue and the output register's valid flag.
module sjis_glyph_index_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,        // face_select
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,    // text_byte
    input  logic                          i_s_axis_tlast,    // end_of_text
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [7:0] half_code, [14:8] row_index, [21:15] column_index, [22] face_bank,
    // [27:23] external_letter, [28] external_upper, [31:29] zero
    output logic [sgd_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    output logic [sgd_pkg::TUSER_W-1:0]   o_m_axis_tuser,    // glyph_kind
    output logic                          o_m_axis_tlast     // last_of_run
);
    import sgd_pkg::*;

    localparam int EntryW = $bits(t_entry);

    logic              queue_full;
    logic              push;
    t_entry            push_entry;
    logic              pop;
    logic              head_valid;
    logic [EntryW-1:0] head_bits;
    t_entry            head_entry;
    t_glyph            out_glyph;

    assign o_cfg_ready = 1'b1;

    sgd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_byte       (i_s_axis_tdata),
        .i_eot        (i_s_axis_tlast),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    sgd_queue #(
        .WIDTH (EntryW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_bits)
    );

    assign head_entry = head_bits;

    sgd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_glyph (out_glyph),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = out_glyph.kind;
    assign o_m_axis_tdata = {3'b000,
                             out_glyph.external_upper,
                             out_glyph.external_letter,
                             out_glyph.face_bank,
                             out_glyph.column_index,
                             out_glyph.row_index,
                             out_glyph.half_code};

endmodule

// ===== rtl/sgd_checker.sv =====
// Port-level checks for the glyph index decoder, bound to the top level.
`timescale 1ns / 1ps

module sgd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [sgd_pkg::TDATA_W-1:0] o_m_axis_tdata,
    input logic [sgd_pkg::TUSER_W-1:0] o_m_axis_tuser,
    input logic                        o_m_axis_tlast
);
    import sgd_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_full_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_FULL |->
            o_m_axis_tdata[14:8] <= 7'd95 && o_m_axis_tdata[21:15] <= 7'd93
            && o_m_axis_tdata[7:0] == 8'd0 && o_m_axis_tdata[28:23] == 6'd0)
        else $error("full-width result out of range");

    a_ext_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_EXT |->
            o_m_axis_tdata[27:23] <= 5'd25 && o_m_axis_tdata[21:0] == 22'd0)
        else $error("external result out of range");

    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_BAD |->
            o_m_axis_tdata[21:0] == 22'd0 && o_m_axis_tdata[31:23] == 9'd0
            && o_m_axis_tlast)
        else $error("invalid-byte result carries payload or is not last");

endmodule

bind sjis_glyph_index_decoder_unit sgd_checker u_sgd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
